// ===== rtl/crhs_pkg.sv =====
package crhs_pkg;
	localparam int unsigned InputBits = 31;
	localparam int unsigned FractionBits = 16;
	localparam int unsigned RootBits = 16;
	localparam int unsigned EstBits = 32;
	// dividend (g*g + n) << F fits in 33 + F bits
	localparam int unsigned DivBits = 33 + FractionBits;
	localparam int unsigned DenBits = RootBits + 1;
	localparam int unsigned RootCells = RootBits;
	localparam int unsigned DivCells = DivBits;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] res;
		logic [InputBits-1:0] n;
	} root_word_t;

	typedef struct packed {
		logic [DenBits:0] rem;
		logic [DivBits-1:0] quo;
		logic [DenBits-1:0] den;
		logic [RootBits-1:0] g;
	} div_word_t;
endpackage

// ===== rtl/ceil_root_heron_step_core.sv =====
// ceil_root_heron_step_core
// One Heron square-root step seeded by the ceiling square root.
// Input channel s_axis_*: one word per value, tdata[30:0] = value_in.
// Output channel m_axis_*: tdata[31:0] = root_estimate (Q16.16, truncated),
// tdata[47:32] = ceiling_root. Zero input gives zero for both.
// Flow: a 16-cell digit-by-digit root chain, one correction stage forming
// the seed and g*g + n, then a 49-cell restoring divide chain by 2g, then
// a saturate stage into an output register.
// A word holds the whole chain until its result is taken, so no new word
// is accepted while one is in flight or parked in the output register.
// s_axis_tready is high only when the chain and output register are empty.
// Reset clears all valid flags; no word is in flight after reset.
// A stalled receiver holds the output word steady until m_axis_tready.
module ceil_root_heron_step_core import crhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [30:0] value_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // [31:0] root_estimate, [47:32] ceiling_root
);
	logic busy_q;
	logic in_acc;

	logic       rv [RootCells+1];
	root_word_t rw [RootCells+1];
	logic       dv [DivCells+1];
	div_word_t  dw [DivCells+1];

	logic         fix_valid_s1;
	div_word_t    fix_word_s1;
	logic         zero_s1;
	logic         zero_d [DivCells+1];

	logic [EstBits-1:0]  est_q;
	logic [RootBits-1:0] root_q;
	logic                out_valid_q;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !busy_q;

	always_comb begin
		rv[0] = in_acc;
		rw[0].rem = {1'b0, s_axis_tdata[InputBits-1:0]};
		rw[0].res = '0;
		rw[0].n = s_axis_tdata[InputBits-1:0];
	end

	for (genvar i = 0; i < RootCells; i++) begin : g_root
		crhs_root_cell u_cell (
			.clk, .arst_n,
			.bit_mask(32'(1) << (30 - 2 * i)),
			.in_valid(rv[i]), .in_word(rw[i]),
			.out_valid(rv[i+1]), .out_word(rw[i+1])
		);
	end

	// bump floor root to ceiling, build dividend and divisor
	logic [RootBits-1:0] fl_root, ce_root;
	logic [32:0] fl_sq, ce_sq, num;
	always_comb begin
		fl_root = rw[RootCells].res[RootBits-1:0];
		fl_sq = 33'(fl_root) * 33'(fl_root);
		ce_root = (fl_sq < 33'(rw[RootCells].n)) ? fl_root + 1'b1 : fl_root;
		ce_sq = (fl_sq < 33'(rw[RootCells].n))
			? fl_sq + {fl_root, 1'b0} + 33'd1 : fl_sq;
		num = ce_sq + 33'(rw[RootCells].n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fix_valid_s1 <= 1'b0;
		else fix_valid_s1 <= rv[RootCells];
	end

	always_ff @(posedge clk) begin
		if (rv[RootCells]) begin
			fix_word_s1.rem <= '0;
			fix_word_s1.quo <= {num, {FractionBits{1'b0}}};
			fix_word_s1.den <= {ce_root, 1'b0};
			fix_word_s1.g   <= ce_root;
			zero_s1 <= (rw[RootCells].n == '0);
		end
	end

	assign dv[0] = fix_valid_s1;
	assign dw[0] = fix_word_s1;
	assign zero_d[0] = zero_s1;

	for (genvar j = 0; j < DivCells; j++) begin : g_div
		crhs_div_cell u_cell (
			.clk, .arst_n,
			.in_valid(dv[j]), .in_word(dw[j]),
			.out_valid(dv[j+1]), .out_word(dw[j+1])
		);
		always_ff @(posedge clk) begin
			if (dv[j]) zero_d[j+1] <= zero_d[j];
		end
	end

	// saturate and park the word for the receiver
	logic [DivBits-1:0] q_fin;
	assign q_fin = dw[DivCells].quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (in_acc) busy_q <= 1'b1;
			if (dv[DivCells]) out_valid_q <= 1'b1;
			else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dv[DivCells]) begin
			if (zero_d[DivCells]) est_q <= '0;
			else if (q_fin[DivBits-1:EstBits] != '0) est_q <= '1;
			else est_q <= q_fin[EstBits-1:0];
			root_q <= zero_d[DivCells] ? '0 : dw[DivCells].g;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {root_q, est_q};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_axis_tready) else $error("accept while busy");
	a_out_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> busy_q) else $error("output without word in flight");
	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> busy_q) else $error("busy not set");
	a_seed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> root_q <= 16'd46341) else $error("seed out of range");
endmodule

// ===== rtl/crhs_root_cell.sv =====
module crhs_root_cell import crhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] bit_mask,
	input  logic        in_valid,
	input  root_word_t  in_word,
	output logic        out_valid,
	output root_word_t  out_word
);
	logic [31:0] trial;
	root_word_t nxt;
	logic valid_q;
	root_word_t word_q;

	always_comb begin
		trial = in_word.res + bit_mask;
		nxt = in_word;
		if (in_word.rem >= trial) begin
			nxt.rem = in_word.rem - trial;
			nxt.res = (in_word.res >> 1) + bit_mask;
		end else begin
			nxt.res = in_word.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid) word_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;
endmodule

// ===== rtl/crhs_div_cell.sv =====
module crhs_div_cell import crhs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  div_word_t in_word,
	output logic      out_valid,
	output div_word_t out_word
);
	logic [DenBits+1:0] shifted;
	div_word_t nxt;
	logic valid_q;
	div_word_t word_q;

	// shift in the top dividend bit, restore on negative
	always_comb begin
		shifted = {in_word.rem, in_word.quo[DivBits-1]};
		nxt = in_word;
		nxt.quo = {in_word.quo[DivBits-2:0], 1'b0};
		if (shifted >= {1'b0, 1'b0, in_word.den}) begin
			nxt.rem = (DenBits+1)'(shifted - {2'b00, in_word.den});
			nxt.quo[0] = 1'b1;
		end else begin
			nxt.rem = shifted[DenBits:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid) word_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import crhs_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // [30:0] value_in, [31] pad
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // [31:0] root_estimate, [47:32] ceiling_root

	typedef struct packed {
		logic [RootBits-1:0] seed;
		logic [EstBits-1:0]  estimate;
	} root_word_t;

	localparam int unsigned QuietLimit = 20000;

	root_word_t expected_roots[$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	bit stall_enable = 1'b1;

	ceil_root_heron_step_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #4 clk = ~clk;

	// Ceiling root and one Heron step, computed exactly in 64-bit arithmetic.
	function automatic root_word_t heron_step(logic [31:0] raw);
		logic [63:0] n;
		logic [63:0] g;
		logic [63:0] q;
		root_word_t r;
		n = {33'd0, raw[InputBits-1:0]};
		r = '0;
		if (n != 0) begin
			g = 0;
			// binary search for the smallest g with g*g >= n
			for (int b = 16; b >= 0; b--) begin
				if ((g + (64'd1 << b)) * (g + (64'd1 << b)) < n)
					g = g + (64'd1 << b);
			end
			g = g + 1;
			q = ((g * g + n) << FractionBits) / (2 * g);
			r.estimate = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
			r.seed = g[15:0];
		end
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Drive one word and hold it until accepted; idle in bursts beforehand.
	// Valid stays high after the accept until the next call updates it.
	task automatic send_word(logic [31:0] data);
		if ($urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= {$urandom};
			repeat ($urandom_range(1, 90)) @(negedge clk);
		end
		s_axis_tdata <= data;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_roots.push_back(heron_step(data));
		@(negedge clk);
	endtask

	// Receiver stall pattern: long ready stretches and random stalls.
	always @(negedge clk) begin
		if (!stall_enable)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(0, 3) != 0);
	end

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		root_word_t want;
		root_word_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_roots.size() == 0) begin
				report("unexpected word", m_axis_tdata, 0);
			end else begin
				want = expected_roots.pop_front();
				if (got.estimate !== want.estimate)
					report("root_estimate", got.estimate, want.estimate);
				if (got.seed !== want.seed)
					report("ceiling_root", got.seed, want.seed);
			end
		end
	end

	// Watchdog: abort after a long run with no accepted word.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic test_directed();
		logic [31:0] corners[$];
		corners = {32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd15, 32'd16, 32'd17,
			32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'd2147395600, 32'd2147395601,
			32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h5555_5555,
			32'h2AAA_AAAA, 32'd65535, 32'd65536, 32'd1000000};
		foreach (corners[i])
			send_word(corners[i]);
	endtask

	task automatic test_random(int unsigned count);
		logic [31:0] v;
		for (int unsigned i = 0; i < count; i++) begin
			case ($urandom_range(0, 4))
				0: v = $urandom_range(0, 300);
				1: begin
					// near a perfect square
					v = $urandom_range(1, 46340);
					v = v * v + $urandom_range(0, 2) - 1;
				end
				default: v = $urandom;
			endcase
			// toggle stretches without receiver stalls
			if (i % 200 == 0)
				stall_enable = ~stall_enable;
			send_word(v);
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1230);
		s_axis_tvalid <= 1'b0;
		while (expected_roots.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
